// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int MAX_RESULTS     = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                   MAX_PATTERN : MAX_REPLACEMENT;

  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_REG_W   = 4;
  localparam int LEN_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN       = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LEN   = 4'd3;

  // One output burst: count bytes in order, count zero with last is a marker
  typedef struct packed {
    logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
    logic [LEN_W-1:0]                   count;
    logic                               last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- hw/rtl/sfr_front.sv -----
// ----------------------------------------------------------------------------
// sfr_front
// Accepts text bytes, keeps the pending window, compares it against the
// pattern and issues one output burst per input byte that yields results.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      in_byte,
  input  logic                   in_last,
  input  q_status_t              q_status,
  output logic                   push,
  output cmd_t                   push_cmd
);

  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [LEN_REG_W-1:0]  pattern_len;
  logic [CFG_DATA_W-1:0] replacement_bytes;
  logic [LEN_REG_W-1:0]  replacement_len;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window, window_next;
  logic [LEN_W-1:0]                   count, count_next;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_ext;
  logic [LEN_W-1:0] plen, rlen, cnt1;
  logic             full, match, accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Clamp lengths to their legal ranges
  always_comb begin
    if (pattern_len == '0) begin
      plen = LEN_W'(1);
    end else if (pattern_len > LEN_REG_W'(MAX_PATTERN)) begin
      plen = LEN_W'(MAX_PATTERN);
    end else begin
      plen = LEN_W'(pattern_len);
    end
    if (replacement_len > LEN_REG_W'(MAX_REPLACEMENT)) begin
      rlen = LEN_W'(MAX_REPLACEMENT);
    end else begin
      rlen = LEN_W'(replacement_len);
    end
  end

  always_comb begin
    win_ext = window;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) == count) win_ext[i] = in_byte;
    end
    cnt1 = count + LEN_W'(1);
    full = (cnt1 == plen);
    match = full;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (LEN_W'(i) < plen && win_ext[i] != pattern_bytes[BYTE_W*i +: BYTE_W]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    push_cmd.bytes = '0;
    push_cmd.last  = in_last;
    if (match) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        push_cmd.bytes[i] = replacement_bytes[BYTE_W*i +: BYTE_W];
      end
      push_cmd.count = rlen;
    end else begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        push_cmd.bytes[i] = win_ext[i];
      end
      // flush everything on the last byte, else emit only the oldest once the window is full
      if (in_last) begin
        push_cmd.count = cnt1;
      end else if (full) begin
        push_cmd.count = LEN_W'(1);
      end else begin
        push_cmd.count = '0;
      end
    end
    push = accept && (push_cmd.count != '0 || in_last);
  end

  always_comb begin
    window_next = window;
    count_next  = count;
    if (accept) begin
      if (match || in_last) begin
        window_next = win_ext;
        count_next  = '0;
      end else if (full) begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          window_next[i] = win_ext[i+1];
        end
        count_next = plen - LEN_W'(1);
      end else begin
        window_next = win_ext;
        count_next  = cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    window <= window_next;
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= '0;
      pattern_len       <= LEN_REG_W'(1);
      replacement_bytes <= '0;
      replacement_len   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BYTES:     pattern_bytes <= cfg_data;
        REG_PATTERN_LEN: begin
          // hold the length while bytes are pending
          if (count == '0) pattern_len <= cfg_data[LEN_REG_W-1:0];
        end
        REG_REPLACEMENT_BYTES: replacement_bytes <= cfg_data;
        REG_REPLACEMENT_LEN:   replacement_len <= cfg_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sfr_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// sfr_cmd_queue
// Short queue of output bursts between front and back.
// ----------------------------------------------------------------------------
module sfr_cmd_queue import sfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign head         = entries[rd_ptr];
  assign status.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   fill <= fill + QCNT_W'(1);
        2'b01:   fill <= fill - QCNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sfr_back.sv -----
// ----------------------------------------------------------------------------
// sfr_back
// Takes bursts from the queue and streams their bytes out, one per transaction.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              head,
  input  q_status_t         q_status,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              byte_valid,
  output logic              out_last
);

  cmd_t             cur;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             final_pos, done;

  assign final_pos  = (cur.count == '0) || (LEN_W'(idx) == cur.count - LEN_W'(1));
  assign done       = busy && out_ready && final_pos;
  assign pop        = (!busy || done) && !q_status.empty;

  assign out_valid  = busy;
  assign byte_valid = (cur.count != '0);
  assign out_byte   = byte_valid ? cur.bytes[idx] : '0;
  assign out_last   = cur.last && final_pos;

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && out_ready) begin
      idx <= idx + IDX_W'(1);
    end
  end

endmodule

// ----- hw/rtl/stream_find_replace.sv -----
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming non-overlapping find-and-replace of a pattern in a byte stream.
// ----------------------------------------------------------------------------
// Path: a byte's burst is written into the queue, then popped into the back's burst register and offered from there.
// Throughput: one input byte per cycle while the queue is not full; output is one
// byte per cycle while out_ready is high, so a replacement longer than one byte
// holds the input once the two-entry burst queue fills.
// Reset: synchronous; clears window count, queue and configuration.
module stream_find_replace import sfr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      in_byte,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   byte_valid,
  output logic                   out_last
);

  q_status_t q_status;
  cmd_t      push_cmd, head;
  logic      push, pop;

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  sfr_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  sfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last)
  );

endmodule

// ----- hw/rtl/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the find-and-replace block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic        out_last
);

  logic [3:0] open_texts;
  logic       in_end, out_end;
  logic [9:0] out_word;

  assign in_end   = in_valid && in_ready && in_last;
  assign out_end  = out_valid && out_ready && out_last;
  assign out_word = {out_byte, byte_valid, out_last};

  // Count texts whose final byte went in but whose final result is still due
  always_ff @(posedge clk) begin
    if (rst) begin
      open_texts <= '0;
    end else begin
      case ({in_end, out_end})
        2'b10:   open_texts <= open_texts + 4'd1;
        2'b01:   open_texts <= open_texts - 4'd1;
        default: ;
      endcase
    end
  end

  `SFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  `SFR_ASSERT_IMPL(a_marker_form, out_valid && !byte_valid, out_last && out_byte == 8'd0)
  `SFR_ASSERT_IMPL(a_idle_after_reset, $past(rst), !out_valid)
  `SFR_ASSERT_IMPL(a_end_has_text, out_end, open_texts != 4'd0)

endmodule

bind stream_find_replace sfr_checker u_checker (.*);
